>>> sv/piarx_pkg.sv
// Shared widths, register indexes and handshake types for the PI loop with ARX plant.
package piarx_pkg;

	// Signal and coefficient formats
	localparam int SIG_W   = 32;            // Q16.16 signals
	localparam int CF_W    = 16;            // Q4.12 coefficients
	localparam int DT_W    = 16;            // Q0.16 sample period
	localparam int U_SHIFT = 28;            // PI sum is Q.44
	localparam int Y_SHIFT = 12;            // ARX sum is Q.28
	localparam int P_SHIFT = 16;            // kp term alignment within the PI sum

	// Digit-serial multiplier
	localparam int DIG_W   = 8;
	localparam int MC_W    = SIG_W + 1;     // widest multiplicand is e - e1
	localparam int KIT_W   = CF_W + DT_W + 1;
	localparam int MR_W    = ((KIT_W + DIG_W - 1) / DIG_W) * DIG_W;
	localparam int PR_W    = MC_W + MR_W;
	localparam int NDIG_W  = $clog2(MR_W / DIG_W + 1);
	localparam int CF_DIG  = (CF_W + DIG_W - 1) / DIG_W;
	localparam int DT_DIG  = DT_W / DIG_W + 1;
	localparam int KIT_DIG = MR_W / DIG_W;

	localparam int ACC_W   = CF_W + MC_W + P_SHIFT + 3;

	localparam logic signed [SIG_W-1:0] SIG_MAX = {1'b0, {(SIG_W-1){1'b1}}};
	localparam logic signed [SIG_W-1:0] SIG_MIN = {1'b1, {(SIG_W-1){1'b0}}};

	// Configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_KP = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DT = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_A1 = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A0 = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_B2 = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_B1 = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_B0 = 4'd7;
	localparam logic [DT_W-1:0]      DT_RESET = 16'd655;

	typedef struct packed {
		logic              start;
		logic [NDIG_W-1:0] ndig;
	} mul_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_sts_t;

endpackage

>>> sv/pi_loop_with_arx_plant_step_top.sv
// Top level: incremental PI controller driving a second-order ARX plant, one sample per transfer.
// Each accepted reference sample yields one result: loop error, control value, plant
// output and a clip flag. After reset the first two samples return zeros and leave the
// loop state alone. From input transfer to result a sample goes through the error step,
// eight products on a shared radix-256 digit-serial multiplier (20 digit steps in all,
// each product issued and then accumulated), rounding and saturation of the control and
// plant sums and the load of the output register; a warm-up sample goes straight to the
// output register. A new sample is taken once the previous one sits in the output register.
// Coefficient writes take effect on the next sample and must be made while idle.
module pi_loop_with_arx_plant_step_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [piarx_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [piarx_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [31:0]                     reference,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [31:0]                     loop_error,
	output logic signed [31:0]                     control_value,
	output logic signed [31:0]                     plant_output,
	output logic                                   saturated
);
	import piarx_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_ERR, ST_ISSUE, ST_MUL, ST_RND, ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		OP_KIT, OP_KP, OP_KI, OP_A1, OP_A0, OP_B2, OP_B1, OP_B0
	} op_t;

	typedef struct packed {
		logic                    clip;
		logic signed [SIG_W-1:0] val;
	} sat_t;

	localparam logic [1:0] WARM_DONE = 2'd2;
	localparam logic signed [ACC_W-1:0] U_HALF = ACC_W'(1) <<< (U_SHIFT - 1);
	localparam logic signed [ACC_W-1:0] Y_HALF = ACC_W'(1) <<< (Y_SHIFT - 1);

	function automatic sat_t sat_sig(input logic signed [ACC_W-1:0] v);
		sat_t r;
		logic hi_ones;
		logic hi_zeros;
		hi_ones  = &v[ACC_W-1:SIG_W-1];
		hi_zeros = ~|v[ACC_W-1:SIG_W-1];
		r.clip   = !(hi_ones || hi_zeros);
		r.val    = (hi_ones || hi_zeros) ? v[SIG_W-1:0] : (v[ACC_W-1] ? SIG_MIN : SIG_MAX);
		return r;
	endfunction

	// Configuration registers
	logic signed [CF_W-1:0] kp_q, ki_q, a1_q, a0_q, b2_q, b1_q, b0_q;
	logic        [DT_W-1:0] dt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= '0;
			ki_q <= '0;
			dt_q <= DT_RESET;
			a1_q <= '0;
			a0_q <= '0;
			b2_q <= '0;
			b1_q <= '0;
			b0_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_KP: kp_q <= cfg_data[CF_W-1:0];
				REG_KI: ki_q <= cfg_data[CF_W-1:0];
				REG_DT: dt_q <= cfg_data[DT_W-1:0];
				REG_A1: a1_q <= cfg_data[CF_W-1:0];
				REG_A0: a0_q <= cfg_data[CF_W-1:0];
				REG_B2: b2_q <= cfg_data[CF_W-1:0];
				REG_B1: b1_q <= cfg_data[CF_W-1:0];
				REG_B0: b0_q <= cfg_data[CF_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and datapath registers
	state_t                    state_q;
	op_t                       op_q;
	logic [1:0]                warm_q;
	logic                      warm_item_q;
	logic signed [SIG_W-1:0]   ref_q, e_q, u_q, y_q;
	logic signed [SIG_W-1:0]   e1_q, u1_q, u2_q, y1_q, y2_q;
	logic signed [KIT_W-1:0]   kit_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      clip_q;
	logic                      out_valid_q;
	logic signed [SIG_W-1:0]   out_e_q, out_u_q, out_y_q;
	logic                      out_sat_q;

	// Multiplier hookup
	mul_cmd_t                  mul_cmd;
	mul_sts_t                  mul_sts;
	logic signed [MC_W-1:0]    mcand;
	logic        [MR_W-1:0]    mplier;
	logic signed [PR_W-1:0]    product;
	logic signed [ACC_W-1:0]   pa;

	always_comb begin
		mcand       = '0;
		mplier      = '0;
		mul_cmd.ndig = NDIG_W'(CF_DIG);
		case (op_q)
			OP_KIT: begin
				mcand        = MC_W'(ki_q);
				mplier       = {{DIG_W{1'b0}}, dt_q, {(MR_W-DIG_W-DT_W){1'b0}}};
				mul_cmd.ndig = NDIG_W'(DT_DIG);
			end
			OP_KP: begin
				mcand  = MC_W'(e_q) - MC_W'(e1_q);
				mplier = {kp_q, {(MR_W-CF_W){1'b0}}};
			end
			OP_KI: begin
				mcand        = MC_W'(e_q);
				mplier       = {{(MR_W-KIT_W){kit_q[KIT_W-1]}}, kit_q};
				mul_cmd.ndig = NDIG_W'(KIT_DIG);
			end
			OP_A1: begin
				mcand  = MC_W'(y1_q);
				mplier = {a1_q, {(MR_W-CF_W){1'b0}}};
			end
			OP_A0: begin
				mcand  = MC_W'(y2_q);
				mplier = {a0_q, {(MR_W-CF_W){1'b0}}};
			end
			OP_B2: begin
				mcand  = MC_W'(u_q);
				mplier = {b2_q, {(MR_W-CF_W){1'b0}}};
			end
			OP_B1: begin
				mcand  = MC_W'(u1_q);
				mplier = {b1_q, {(MR_W-CF_W){1'b0}}};
			end
			OP_B0: begin
				mcand  = MC_W'(u2_q);
				mplier = {b0_q, {(MR_W-CF_W){1'b0}}};
			end
			default: ;
		endcase
		mul_cmd.start = (state_q == ST_ISSUE);
	end

	piarx_dmul u_dmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (mul_cmd),
		.mcand   (mcand),
		.mplier  (mplier),
		.sts     (mul_sts),
		.product (product)
	);

	assign pa = ACC_W'(product);

	// Error, rounding and saturation
	logic signed [MC_W-1:0]  e_diff;
	sat_t                    e_sat;
	logic                    rnd_u;
	logic signed [ACC_W-1:0] rsum;
	logic signed [ACC_W-1:0] rshift;
	sat_t                    rnd;
	logic                    out_free;

	always_comb begin
		e_diff   = MC_W'(ref_q) - MC_W'(y1_q);
		e_sat    = sat_sig(ACC_W'(e_diff));
		rnd_u    = (op_q == OP_A1);
		rsum     = acc_q + (rnd_u ? U_HALF : Y_HALF);
		rshift   = rnd_u ? (rsum >>> U_SHIFT) : (rsum >>> Y_SHIFT);
		rnd      = sat_sig(rshift);
		out_free = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_KIT;
			warm_q      <= '0;
			warm_item_q <= 1'b0;
			ref_q       <= '0;
			e_q         <= '0;
			u_q         <= '0;
			y_q         <= '0;
			e1_q        <= '0;
			u1_q        <= '0;
			u2_q        <= '0;
			y1_q        <= '0;
			y2_q        <= '0;
			kit_q       <= '0;
			acc_q       <= '0;
			clip_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_e_q     <= '0;
			out_u_q     <= '0;
			out_y_q     <= '0;
			out_sat_q   <= 1'b0;
		end else begin
			// ST_OUT reloads the output register itself
			if (out_valid_q && !out_stall && state_q != ST_OUT)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						ref_q <= reference;
						if (warm_q != WARM_DONE) begin
							warm_item_q <= 1'b1;
							state_q     <= ST_OUT;
						end else begin
							warm_item_q <= 1'b0;
							state_q     <= ST_ERR;
						end
					end
				end
				ST_ERR: begin
					e_q     <= e_sat.val;
					clip_q  <= e_sat.clip;
					op_q    <= OP_KIT;
					state_q <= ST_ISSUE;
				end
				ST_ISSUE: state_q <= ST_MUL;
				ST_MUL: begin
					if (mul_sts.done) begin
						case (op_q)
							OP_KIT: kit_q <= product[KIT_W-1:0];
							OP_KP:  acc_q <= (ACC_W'(u1_q) <<< U_SHIFT) + (pa <<< P_SHIFT);
							OP_A1:  acc_q <= -pa;
							OP_A0:  acc_q <= acc_q - pa;
							default: acc_q <= acc_q + pa;
						endcase
						op_q    <= op_t'(op_q + 3'd1);
						state_q <= (op_q == OP_KI || op_q == OP_B0) ? ST_RND : ST_ISSUE;
					end
				end
				ST_RND: begin
					// op_q already points past the last product of the sum
					if (rnd_u) begin
						u_q     <= rnd.val;
						state_q <= ST_ISSUE;
					end else begin
						y_q     <= rnd.val;
						state_q <= ST_OUT;
					end
					clip_q <= clip_q | rnd.clip;
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (warm_item_q) begin
							out_e_q   <= '0;
							out_u_q   <= '0;
							out_y_q   <= '0;
							out_sat_q <= 1'b0;
							warm_q    <= warm_q + 2'd1;
						end else begin
							out_e_q   <= e_q;
							out_u_q   <= u_q;
							out_y_q   <= y_q;
							out_sat_q <= clip_q;
							e1_q      <= e_q;
							u2_q      <= u1_q;
							u1_q      <= u_q;
							y2_q      <= y1_q;
							y1_q      <= y_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = out_valid_q;
	assign loop_error    = out_e_q;
	assign control_value = out_u_q;
	assign plant_output  = out_y_q;
	assign saturated     = out_sat_q;

	// Checks
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		mul_cmd.start |-> !mul_sts.busy)
		else $error("multiplier restarted while busy");

	a_sat_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |->
		(loop_error == SIG_MAX || loop_error == SIG_MIN ||
		 control_value == SIG_MAX || control_value == SIG_MIN ||
		 plant_output == SIG_MAX || plant_output == SIG_MIN))
		else $error("clip flag set with no result on a rail");

	a_warm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free && warm_item_q) |=>
		(out_valid && loop_error == '0 && control_value == '0 &&
		 plant_output == '0 && !saturated))
		else $error("warm-up result not zero");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != ST_IDLE))
		else $error("input transfer did not start a sample");

endmodule

>>> sv/piarx_dmul.sv
// Radix-256 digit-serial signed multiplier, most significant digit first.
module piarx_dmul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  piarx_pkg::mul_cmd_t                 cmd,
	input  logic signed [piarx_pkg::MC_W-1:0]   mcand,
	input  logic        [piarx_pkg::MR_W-1:0]   mplier,
	output piarx_pkg::mul_sts_t                 sts,
	output logic signed [piarx_pkg::PR_W-1:0]   product
);
	import piarx_pkg::*;

	logic signed [MC_W-1:0]       mc_q;
	logic        [MR_W-1:0]       mr_q;
	logic        [NDIG_W-1:0]     cnt_q;
	logic                         first_q;
	logic                         busy_q;
	logic                         done_q;
	logic signed [PR_W-1:0]       p_q;

	logic        [DIG_W-1:0]      dig;
	logic signed [DIG_W:0]        dig_s;
	logic signed [MC_W+DIG_W:0]   part;
	logic signed [PR_W-1:0]       p_next;

	// top digit of the multiplier is signed, the rest unsigned
	always_comb begin
		dig    = mr_q[MR_W-1 -: DIG_W];
		dig_s  = first_q ? {dig[DIG_W-1], dig} : {1'b0, dig};
		part   = (MC_W+DIG_W+1)'(mc_q) * (MC_W+DIG_W+1)'(dig_s);
		p_next = (first_q ? PR_W'(0) : (p_q <<< DIG_W)) + PR_W'(part);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mc_q    <= '0;
			mr_q    <= '0;
			cnt_q   <= '0;
			first_q <= 1'b0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			p_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				mc_q    <= mcand;
				mr_q    <= mplier;
				cnt_q   <= cmd.ndig;
				first_q <= 1'b1;
				busy_q  <= 1'b1;
			end else if (busy_q) begin
				p_q     <= p_next;
				mr_q    <= mr_q << DIG_W;
				cnt_q   <= cnt_q - NDIG_W'(1);
				first_q <= 1'b0;
				if (cnt_q == NDIG_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign product  = p_q;

endmodule

>>> tb/pi_loop_with_arx_plant_step_checker.sv
`timescale 1ns / 100ps
// Checker for the PI loop with ARX plant: predicts every step and compares the result transfers.
module pi_loop_with_arx_plant_step_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [piarx_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [piarx_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic signed [31:0]                  reference,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic signed [31:0]                  loop_error,
	input  logic signed [31:0]                  control_value,
	input  logic signed [31:0]                  plant_output,
	input  logic                                saturated,
	output int                                  failures,
	output int                                  pending
);
	import piarx_pkg::*;

	typedef struct packed {
		logic signed [SIG_W-1:0] err;
		logic signed [SIG_W-1:0] ctl;
		logic signed [SIG_W-1:0] plant;
		logic                    clip;
	} loop_result_t;

	// coefficient copy
	logic signed [CF_W-1:0] kp, ki, a1, a0, b2, b1, b0;
	logic [DT_W-1:0]        dt;

	// loop state
	logic signed [SIG_W-1:0] e1, u1, u2, y1, y2;
	logic [1:0]              warm;

	loop_result_t loop_results_q[$];

	function automatic logic signed [SIG_W-1:0] clamp_q16(input logic signed [127:0] v,
		output logic hit);
		logic signed [127:0] hi_lim, lo_lim;
		hi_lim = SIG_MAX;
		lo_lim = SIG_MIN;
		hit = 1'b0;
		if (v > hi_lim) begin
			hit = 1'b1;
			return SIG_MAX;
		end
		if (v < lo_lim) begin
			hit = 1'b1;
			return SIG_MIN;
		end
		return v[SIG_W-1:0];
	endfunction

	task automatic compute_loop_step(input logic signed [SIG_W-1:0] ref_in,
		output loop_result_t r);
		logic signed [127:0] w_ref, w_e, w_e1, w_u, w_u1, w_u2, w_y1, w_y2;
		logic signed [127:0] w_kp, w_ki, w_dt, w_a1, w_a0, w_b2, w_b1, w_b0, w_one, acc;
		logic signed [SIG_W-1:0] e, u, y;
		logic hit;
		r = '0;
		if (warm < 2) begin
			// warm-up: zeros out, loop state untouched
			warm = warm + 2'd1;
		end else begin
			w_ref = ref_in;
			w_e1 = e1;
			w_u1 = u1;
			w_u2 = u2;
			w_y1 = y1;
			w_y2 = y2;
			w_kp = kp;
			w_ki = ki;
			w_dt = dt;
			w_a1 = a1;
			w_a0 = a0;
			w_b2 = b2;
			w_b1 = b1;
			w_b0 = b0;
			w_one = 1;

			e = clamp_q16(w_ref - w_y1, hit);
			r.clip = hit;
			w_e = e;

			// PI sum in Q.44
			acc = (w_u1 <<< U_SHIFT) + ((w_kp * (w_e - w_e1)) <<< P_SHIFT)
				+ w_ki * w_dt * w_e;
			u = clamp_q16((acc + (w_one <<< (U_SHIFT - 1))) >>> U_SHIFT, hit);
			r.clip = r.clip | hit;
			w_u = u;

			// ARX sum in Q.28, feedback terms subtracted
			acc = -(w_a1 * w_y1) - w_a0 * w_y2 + w_b2 * w_u + w_b1 * w_u1 + w_b0 * w_u2;
			y = clamp_q16((acc + (w_one <<< (Y_SHIFT - 1))) >>> Y_SHIFT, hit);
			r.clip = r.clip | hit;

			e1 = e;
			u2 = u1;
			u1 = u;
			y2 = y1;
			y1 = y;
			r.err = e;
			r.ctl = u;
			r.plant = y;
		end
	endtask

	task automatic note_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		failures++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		loop_result_t want, got;
		if (!arst_n) begin
			kp = '0;
			ki = '0;
			dt = DT_RESET;
			a1 = '0;
			a0 = '0;
			b2 = '0;
			b1 = '0;
			b0 = '0;
			e1 = '0;
			u1 = '0;
			u2 = '0;
			y1 = '0;
			y2 = '0;
			warm = '0;
			failures = 0;
			loop_results_q.delete();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_KP: kp = cfg_data;
					REG_KI: ki = cfg_data;
					REG_DT: dt = cfg_data;
					REG_A1: a1 = cfg_data;
					REG_A0: a0 = cfg_data;
					REG_B2: b2 = cfg_data;
					REG_B1: b1 = cfg_data;
					REG_B0: b0 = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				compute_loop_step(reference, want);
				loop_results_q = {loop_results_q, want};
			end
			if (out_valid && !out_stall) begin
				got = '{loop_error, control_value, plant_output, saturated};
				if (loop_results_q.size() == 0) begin
					note_mismatch("result transfer with no prediction waiting");
				end else begin
					want = loop_results_q.pop_front();
					if (got.err !== want.err)
						note_mismatch($sformatf("loop_error %h, expected %h",
							got.err, want.err));
					if (got.ctl !== want.ctl)
						note_mismatch($sformatf("control_value %h, expected %h",
							got.ctl, want.ctl));
					if (got.plant !== want.plant)
						note_mismatch($sformatf("plant_output %h, expected %h",
							got.plant, want.plant));
					if (got.clip !== want.clip)
						note_mismatch($sformatf("saturated %b, expected %b",
							got.clip, want.clip));
				end
			end
		end
		pending <= loop_results_q.size();
	end

endmodule

>>> tb/pi_loop_with_arx_plant_step_top_tb.sv
`timescale 1ns / 100ps
// Testbench top: drives reference samples and coefficient writes into the PI loop, gives the verdict.
module pi_loop_with_arx_plant_step_top_tb;
	import piarx_pkg::*;

	localparam int RANDOM_PHASES  = 10;
	localparam int PHASE_SAMPLES  = 137;
	localparam int IDLE_MAX       = 12;
	localparam int LONG_HOLD      = 150;
	localparam int DRAIN_CYCLES   = 60;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef enum int {CF_MODERATE, CF_FULL, CF_EXTREME, CF_NO_DT} coef_kind_t;

	typedef struct packed {
		logic [CF_W-1:0] kp, ki, dt, a1, a0, b2, b1, b0;
	} coef_set_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_wr_en;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_data;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [31:0]       reference;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [31:0]       loop_error;
	logic signed [31:0]       control_value;
	logic signed [31:0]       plant_output;
	logic                     saturated;
	int                       failures;
	int                       pending;

	bit send_idle_on;
	bit recv_idle_on;
	bit long_hold;
	int quiet_cycles;

	pi_loop_with_arx_plant_step_top u_top (.*);

	pi_loop_with_arx_plant_step_checker u_checker (.*);

	always #1 clk = ~clk;

	// result side: random hold-offs, one long one on request
	initial begin
		int n;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				n = LONG_HOLD;
			end else begin
				n = recv_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (!(out_valid && !out_stall)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [CF_W-1:0] extreme_coef();
		case ($urandom_range(0, 4))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'h0001;
		endcase
	endfunction

	function automatic logic signed [31:0] extreme_sample();
		case ($urandom_range(0, 3))
			0: return SIG_MAX;
			1: return SIG_MIN;
			2: return 32'sd0;
			default: return -32'sd1;
		endcase
	endfunction

	// roughly +-16.0 in Q16.16
	function automatic logic signed [31:0] small_sample();
		logic [31:0] r;
		r = $urandom;
		return {{11{r[20]}}, r[20:0]};
	endfunction

	function automatic coef_set_t draw_coefs(input coef_kind_t kind);
		coef_set_t c;
		c = {8{16'($urandom)}};
		case (kind)
			CF_FULL: begin
				c.kp = 16'($urandom);
				c.ki = 16'($urandom);
				c.dt = 16'($urandom);
				c.a1 = 16'($urandom);
				c.a0 = 16'($urandom);
				c.b2 = 16'($urandom);
				c.b1 = 16'($urandom);
				c.b0 = 16'($urandom);
			end
			CF_EXTREME: begin
				c.kp = extreme_coef();
				c.ki = extreme_coef();
				c.dt = extreme_coef();
				c.a1 = extreme_coef();
				c.a0 = extreme_coef();
				c.b2 = extreme_coef();
				c.b1 = extreme_coef();
				c.b0 = extreme_coef();
			end
			default: begin
				// gains and a plant that mostly stay in range
				c.kp = 16'($urandom_range(0, 16383)) - 16'd8192;
				c.ki = 16'($urandom_range(0, 4095)) - 16'd2048;
				c.dt = (kind == CF_NO_DT) ? 16'd0 : 16'($urandom_range(1, 65535));
				c.a1 = 16'd0 - 16'($urandom_range(4096, 7000));
				c.a0 = 16'($urandom_range(500, 3000));
				c.b2 = 16'($urandom_range(0, 4095)) - 16'd2048;
				c.b1 = 16'($urandom_range(0, 4095)) - 16'd2048;
				c.b0 = 16'($urandom_range(0, 4095)) - 16'd2048;
			end
		endcase
		return c;
	endfunction

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic apply_coefs(input coef_set_t c);
		put_reg(REG_KP, c.kp);
		put_reg(REG_KI, c.ki);
		put_reg(REG_DT, c.dt);
		put_reg(REG_A1, c.a1);
		put_reg(REG_A0, c.a0);
		put_reg(REG_B2, c.b2);
		put_reg(REG_B1, c.b1);
		put_reg(REG_B0, c.b0);
		// unmapped index, must not disturb anything
		put_reg(REG_B0 + CFG_IDX_W'($urandom_range(1, 8)), 16'($urandom));
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(input logic signed [31:0] v);
		int gap;
		gap = send_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
		in_valid <= 1'b1;
		reference <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering and wait for every outstanding result
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		coef_set_t c;
		coef_kind_t kind;
		logic signed [31:0] level, s;
		int hold_left;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_KP;
		cfg_data <= '0;
		in_valid <= 1'b0;
		reference <= '0;
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
		long_hold = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coefficients: two warm-up samples, then the error passes straight through
		send_sample(SIG_MAX);
		send_sample(SIG_MIN);
		send_sample(SIG_MAX);
		send_sample(SIG_MIN);
		settle();

		c = '{16'h1000, 16'h2000, DT_RESET, 16'hE666, 16'h0A8F, 16'h019A, 16'h00CD, 16'h0066};
		apply_coefs(c);
		send_sample(32'sd0);
		send_sample(32'sd1);
		send_sample(-32'sd1);
		send_sample(32'sh00010000);
		send_sample(SIG_MAX);
		send_sample(SIG_MAX);
		send_sample(SIG_MIN);
		send_sample(32'sh55555555);
		send_sample(32'shAAAAAAAA);
		settle();

		// extreme coefficients, everything clips
		c = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF};
		apply_coefs(c);
		send_sample(32'sd0);
		send_sample(SIG_MAX);
		send_sample(SIG_MIN);
		send_sample(32'sd1);
		send_sample(-32'sd1);
		send_sample(32'sd0);
		settle();

		// zero sample period: integral term drops out
		c = '{16'h0000, 16'h7FFF, 16'h0000, 16'hF000, 16'h0400, 16'h0800, 16'hFC00, 16'h0200};
		apply_coefs(c);
		send_sample(32'sh00100000);
		send_sample(-32'sh00100000);
		send_sample(32'sd0);
		send_sample(SIG_MAX);
		send_sample(SIG_MIN);
		send_sample(32'sd0);
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: kind = CF_MODERATE;
				5: kind = CF_NO_DT;
				7: kind = CF_EXTREME;
				8: kind = CF_FULL;
				default: kind = coef_kind_t'($urandom_range(0, 3));
			endcase
			apply_coefs(draw_coefs(kind));
			// phase 1 runs flat out; phase 2 fills the block behind a long hold-off
			send_idle_on = (p == 1 || p == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
			recv_idle_on = (p == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
			if (p == 2)
				long_hold = 1'b1;
			hold_left = 0;
			level = '0;
			for (int i = 0; i < PHASE_SAMPLES; i++) begin
				if (p == 3 && i == PHASE_SAMPLES / 2)
					settle();
				// mostly setpoint steps held for a while, some wild values
				if (hold_left == 0) begin
					case ($urandom_range(0, 9))
						0, 1: level = $urandom;
						2: level = extreme_sample();
						default: level = small_sample();
					endcase
					hold_left = $urandom_range(1, 30);
				end
				hold_left--;
				s = level;
				if ($urandom_range(0, 4) == 0)
					s = level + (small_sample() >>> 8);
				send_sample(s);
			end
			settle();
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
